@@ hdl/motion_accel_and_yaw_unwrap_macros.svh @@
// assertion helpers used by the top-level rtl
`ifndef MOTION_ACCEL_AND_YAW_UNWRAP_MACROS_SVH
`define MOTION_ACCEL_AND_YAW_UNWRAP_MACROS_SVH

// condition holds at every edge out of reset
`define MAU_ASSERT_ALWAYS(label, clk, rst_n, cond) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error("mau: check failed");

// antecedent at one edge implies consequent at the next
`define MAU_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("mau: check failed");

`endif

@@ hdl/mau_pkg.sv @@
`timescale 1ns / 1ps
package mau_pkg;

  localparam int CfgIdxW  = 3;
  localparam int CfgDataW = 16;

  localparam logic [CfgIdxW-1:0] CfgLpfAlpha    = 3'd0;
  localparam logic [CfgIdxW-1:0] CfgGravity     = 3'd1;
  localparam logic [CfgIdxW-1:0] CfgDeadbandXy  = 3'd2;
  localparam logic [CfgIdxW-1:0] CfgDeadbandZ   = 3'd3;
  localparam logic [CfgIdxW-1:0] CfgWarmupItems = 3'd4;

  localparam int QDepth = 2;
  localparam int QPtrW  = $clog2(QDepth);
  localparam int QCntW  = $clog2(QDepth + 1);

  localparam logic signed [16:0] YawHalfTurn = 17'sd25736;
  localparam logic signed [32:0] YawFullTurn = 33'sd51470;

  typedef struct packed {
    logic [15:0] lpf_alpha;
    logic [14:0] gravity_level;
    logic [11:0] deadband_xy;
    logic [11:0] deadband_z;
    logic [15:0] warmup_items;
  } mau_cfg_t;

  typedef struct packed {
    logic signed [15:0] quat_w;
    logic signed [15:0] quat_x;
    logic signed [15:0] quat_y;
    logic signed [15:0] quat_z;
    logic signed [19:0] accel_x;
    logic signed [19:0] accel_y;
    logic signed [19:0] accel_z;
    logic signed [15:0] yaw_angle;
  } mau_in_t;

  typedef struct packed {
    logic signed [19:0] motion_north;
    logic signed [19:0] motion_east;
    logic signed [19:0] motion_up;
    logic signed [31:0] yaw_total;
    logic               attitude_ready;
  } mau_out_t;

  typedef struct packed {
    mau_in_t            item;
    logic signed [31:0] yaw_total;
    logic               ready;
  } mau_job_t;

  // round to nearest, halves away from zero
  function automatic logic signed [59:0] round_shift(input logic signed [59:0] v,
                                                     input int unsigned sh);
    logic [59:0] half;
    logic [59:0] mag;
    logic [59:0] q;
    half = 60'd1 << (sh - 1);
    mag  = v[59] ? 60'(-v) : 60'(v);
    q    = (mag + half) >> sh;
    return v[59] ? -$signed(q) : $signed(q);
  endfunction

  function automatic logic signed [19:0] sat20(input logic signed [59:0] v);
    if (v > 60'sd524287) return 20'sh7ffff;
    if (v < -60'sd524288) return 20'sh80000;
    return v[19:0];
  endfunction

  function automatic logic signed [19:0] dead_band(input logic signed [19:0] v,
                                                   input logic [11:0] band);
    logic signed [20:0] ext;
    logic [20:0]        mag;
    ext = 21'(v);
    mag = ext[20] ? 21'(-ext) : 21'(ext);
    return (mag < {9'd0, band}) ? 20'sd0 : v;
  endfunction

endpackage

@@ hdl/motion_accel_and_yaw_unwrap.sv @@
`timescale 1ns / 1ps
// the back end finishes one request before it takes the next from the queue: its
// 14-step sequence shares three multipliers, and it holds at the last step while
// the output is stalled
// a two-entry queue lets the front accept requests while the back end works
// reset (async, active low) loads register defaults and clears filter and yaw state
module motion_accel_and_yaw_unwrap (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [mau_pkg::CfgIdxW-1:0]     cfg_idx_i,
  input  logic [mau_pkg::CfgDataW-1:0]    cfg_data_i,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  mau_pkg::mau_in_t                in_data_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output mau_pkg::mau_out_t               out_data_o
);
  import mau_pkg::*;
  `include "motion_accel_and_yaw_unwrap_macros.svh"

  mau_cfg_t cfg_q;
  mau_job_t push_job, pop_job;
  logic     push, pop, q_full, q_valid;
  logic     out_fire;

  assign out_fire = out_valid_o && !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.lpf_alpha     <= 16'd3486;
      cfg_q.gravity_level <= 15'd10045;
      cfg_q.deadband_xy   <= 12'd20;
      cfg_q.deadband_z    <= 12'd41;
      cfg_q.warmup_items  <= 16'd101;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CfgLpfAlpha:    cfg_q.lpf_alpha     <= cfg_data_i;
        CfgGravity:     cfg_q.gravity_level <= cfg_data_i[14:0];
        CfgDeadbandXy:  cfg_q.deadband_xy   <= cfg_data_i[11:0];
        CfgDeadbandZ:   cfg_q.deadband_z    <= cfg_data_i[11:0];
        CfgWarmupItems: cfg_q.warmup_items  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  mau_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .q_full_i   (q_full),
    .push_o     (push),
    .job_o      (push_job)
  );

  mau_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_job),
    .full_o      (q_full),
    .pop_i       (pop),
    .valid_o     (q_valid),
    .pop_data_o  (pop_job)
  );

  mau_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .q_valid_i   (q_valid),
    .q_data_i    (pop_job),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  `MAU_ASSERT_ALWAYS(a_no_pop_empty, clk_i, rst_ni, !(pop && !q_valid))
  `MAU_ASSERT_ALWAYS(a_no_push_full, clk_i, rst_ni, !(push && q_full))
  `MAU_ASSERT_NEXT(a_ready_sticky, clk_i, rst_ni, out_fire && out_data_o.attitude_ready, !out_valid_o || out_data_o.attitude_ready)

endmodule

@@ hdl/mau_front.sv @@
`timescale 1ns / 1ps
module mau_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  mau_pkg::mau_cfg_t cfg_i,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  mau_pkg::mau_in_t  in_data_i,
  input  logic              q_full_i,
  output logic              push_o,
  output mau_pkg::mau_job_t job_o
);
  import mau_pkg::*;

  logic signed [15:0] prev_yaw_q, prev_yaw_d;
  logic signed [15:0] turn_q, turn_d;
  logic [15:0]        wcnt_q, wcnt_d;
  logic               ready_q, ready_d;
  logic signed [31:0] hold_q, hold_d;
  logic signed [16:0] dyaw;
  logic signed [32:0] turn_prod;

  assign in_stall_o = q_full_i;
  assign push_o     = in_valid_i && !q_full_i;

  always_comb begin
    prev_yaw_d = prev_yaw_q;
    turn_d     = turn_q;
    wcnt_d     = wcnt_q;
    ready_d    = ready_q;
    hold_d     = hold_q;
    dyaw       = 17'(in_data_i.yaw_angle) - 17'(prev_yaw_q);
    turn_prod  = 33'sd0;
    if (wcnt_q >= cfg_i.warmup_items) begin
      ready_d = 1'b1;
      if (dyaw >= YawHalfTurn) begin
        if (turn_q != 16'sh8000) turn_d = turn_q - 16'sd1;
      end else if (dyaw <= -YawHalfTurn) begin
        if (turn_q != 16'sh7fff) turn_d = turn_q + 16'sd1;
      end
      // |turns * full turn + yaw| stays inside 32 bits
      turn_prod  = 33'(turn_d) * YawFullTurn;
      hold_d     = turn_prod[31:0] + 32'(in_data_i.yaw_angle);
      prev_yaw_d = in_data_i.yaw_angle;
    end else begin
      wcnt_d = wcnt_q + 16'd1;
    end
    job_o.item      = in_data_i;
    job_o.yaw_total = hold_d;
    job_o.ready     = ready_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_yaw_q <= '0;
      turn_q     <= '0;
      wcnt_q     <= '0;
      ready_q    <= 1'b0;
      hold_q     <= '0;
    end else if (push_o) begin
      prev_yaw_q <= prev_yaw_d;
      turn_q     <= turn_d;
      wcnt_q     <= wcnt_d;
      ready_q    <= ready_d;
      hold_q     <= hold_d;
    end
  end

endmodule

@@ hdl/mau_fifo.sv @@
`timescale 1ns / 1ps
module mau_fifo (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  mau_pkg::mau_job_t push_data_i,
  output logic              full_o,
  input  logic              pop_i,
  output logic              valid_o,
  output mau_pkg::mau_job_t pop_data_o
);
  import mau_pkg::*;

  mau_job_t               mem_q [QDepth];
  logic [QPtrW-1:0]       wr_q, rd_q;
  logic [QCntW-1:0]       cnt_q;

  assign full_o     = (cnt_q == QCntW'(QDepth));
  assign valid_o    = (cnt_q != '0);
  assign pop_data_o = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_q] <= push_data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) wr_q <= (wr_q == QPtrW'(QDepth - 1)) ? '0 : wr_q + 1'b1;
      if (pop_i)  rd_q <= (rd_q == QPtrW'(QDepth - 1)) ? '0 : rd_q + 1'b1;
      if (push_i && !pop_i)      cnt_q <= cnt_q + 1'b1;
      else if (pop_i && !push_i) cnt_q <= cnt_q - 1'b1;
    end
  end

endmodule

@@ hdl/mau_back.sv @@
`timescale 1ns / 1ps
module mau_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  mau_pkg::mau_cfg_t cfg_i,
  input  logic              q_valid_i,
  input  mau_pkg::mau_job_t q_data_i,
  output logic              pop_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output mau_pkg::mau_out_t out_data_o
);
  import mau_pkg::*;

  typedef enum logic {BkIdle, BkBusy} bk_state_e;

  localparam logic [3:0] StSq    = 4'd0;
  localparam logic [3:0] StCross = 4'd1;
  localparam logic [3:0] StWq    = 4'd2;
  localparam logic [3:0] StLatW  = 4'd3;
  localparam logic [3:0] StMat   = 4'd4;
  localparam logic [3:0] StGrav  = 4'd5;
  localparam logic [3:0] StErr   = 4'd6;
  localparam logic [3:0] StAlpha = 4'd7;
  localparam logic [3:0] StFilt  = 4'd8;
  localparam logic [3:0] StRot0  = 4'd9;
  localparam logic [3:0] StRot1  = 4'd10;
  localparam logic [3:0] StRot2  = 4'd11;
  localparam logic [3:0] StSum   = 4'd12;
  localparam logic [3:0] StOut   = 4'd13;

  bk_state_e          state_q;
  logic [3:0]         step_q;
  mau_job_t           job_q;
  logic signed [31:0] xx_q, yy_q, zz_q, xy_q, xz_q, yz_q, wx_q, wy_q, wz_q;
  logic signed [33:0] r_q [3][3];
  logic signed [22:0] e_q [3];
  logic signed [19:0] filt_q [3];
  logic signed [56:0] acc_q [3];
  logic signed [56:0] mp_q [3];
  logic signed [33:0] ma [3];
  logic signed [22:0] mb [3];
  logic signed [19:0] acc_in [3];
  logic signed [19:0] earth [3];
  logic               out_free;
  logic               out_load;
  mau_out_t           out_q;
  logic               out_valid_q;

  assign acc_in[0] = job_q.item.accel_x;
  assign acc_in[1] = job_q.item.accel_y;
  assign acc_in[2] = job_q.item.accel_z;

  assign out_free    = !out_valid_q || !out_stall_i;
  assign out_load    = (state_q == BkBusy) && (step_q == StOut) && out_free;
  assign pop_o       = (state_q == BkIdle) && q_valid_i;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // operand select for the three shared multipliers
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      ma[i] = '0;
      mb[i] = '0;
    end
    case (step_q)
      StSq: begin
        ma[0] = 34'(job_q.item.quat_x); mb[0] = 23'(job_q.item.quat_x);
        ma[1] = 34'(job_q.item.quat_y); mb[1] = 23'(job_q.item.quat_y);
        ma[2] = 34'(job_q.item.quat_z); mb[2] = 23'(job_q.item.quat_z);
      end
      StCross: begin
        ma[0] = 34'(job_q.item.quat_x); mb[0] = 23'(job_q.item.quat_y);
        ma[1] = 34'(job_q.item.quat_x); mb[1] = 23'(job_q.item.quat_z);
        ma[2] = 34'(job_q.item.quat_y); mb[2] = 23'(job_q.item.quat_z);
      end
      StWq: begin
        ma[0] = 34'(job_q.item.quat_w); mb[0] = 23'(job_q.item.quat_x);
        ma[1] = 34'(job_q.item.quat_w); mb[1] = 23'(job_q.item.quat_y);
        ma[2] = 34'(job_q.item.quat_w); mb[2] = 23'(job_q.item.quat_z);
      end
      StGrav: begin
        for (int i = 0; i < 3; i++) begin
          ma[i] = r_q[2][i];
          mb[i] = {8'd0, cfg_i.gravity_level};
        end
      end
      StAlpha: begin
        for (int i = 0; i < 3; i++) begin
          ma[i] = 34'(e_q[i]);
          mb[i] = {7'd0, cfg_i.lpf_alpha};
        end
      end
      StRot0: begin
        for (int i = 0; i < 3; i++) begin
          ma[i] = r_q[i][0]; mb[i] = 23'(filt_q[0]);
        end
      end
      StRot1: begin
        for (int i = 0; i < 3; i++) begin
          ma[i] = r_q[i][1]; mb[i] = 23'(filt_q[1]);
        end
      end
      StRot2: begin
        for (int i = 0; i < 3; i++) begin
          ma[i] = r_q[i][2]; mb[i] = 23'(filt_q[2]);
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      earth[i] = sat20(round_shift(60'(acc_q[i]), 28));
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < 3; i++) begin
      mp_q[i] <= 57'(ma[i]) * 57'(mb[i]);
    end
    if (pop_o) job_q <= q_data_i;
    case (step_q)
      StCross: begin
        xx_q <= mp_q[0][31:0]; yy_q <= mp_q[1][31:0]; zz_q <= mp_q[2][31:0];
      end
      StWq: begin
        xy_q <= mp_q[0][31:0]; xz_q <= mp_q[1][31:0]; yz_q <= mp_q[2][31:0];
      end
      StLatW: begin
        wx_q <= mp_q[0][31:0]; wy_q <= mp_q[1][31:0]; wz_q <= mp_q[2][31:0];
      end
      StMat: begin
        r_q[0][0] <= ((34'sd1 <<< 27) - 34'(yy_q) - 34'(zz_q)) <<< 1;
        r_q[0][1] <= (34'(xy_q) - 34'(wz_q)) <<< 1;
        r_q[0][2] <= (34'(xz_q) + 34'(wy_q)) <<< 1;
        r_q[1][0] <= (34'(xy_q) + 34'(wz_q)) <<< 1;
        r_q[1][1] <= ((34'sd1 <<< 27) - 34'(xx_q) - 34'(zz_q)) <<< 1;
        r_q[1][2] <= (34'(yz_q) - 34'(wx_q)) <<< 1;
        r_q[2][0] <= (34'(xz_q) - 34'(wy_q)) <<< 1;
        r_q[2][1] <= (34'(yz_q) + 34'(wx_q)) <<< 1;
        r_q[2][2] <= ((34'sd1 <<< 27) - 34'(xx_q) - 34'(yy_q)) <<< 1;
      end
      StErr: begin
        for (int i = 0; i < 3; i++) begin
          e_q[i] <= 23'(60'(acc_in[i]) - round_shift(60'(mp_q[i]), 28)
                        - 60'(filt_q[i]));
        end
      end
      StRot1: begin
        for (int i = 0; i < 3; i++) acc_q[i] <= mp_q[i];
      end
      StRot2, StSum: begin
        for (int i = 0; i < 3; i++) acc_q[i] <= acc_q[i] + mp_q[i];
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BkIdle;
      step_q      <= StSq;
      out_valid_q <= 1'b0;
      out_q       <= '0;
      for (int i = 0; i < 3; i++) filt_q[i] <= '0;
    end else begin
      if (out_valid_q && !out_stall_i && !out_load) out_valid_q <= 1'b0;
      if (step_q == StFilt && state_q == BkBusy) begin
        for (int i = 0; i < 3; i++) begin
          filt_q[i] <= sat20(60'(filt_q[i]) + round_shift(60'(mp_q[i]), 16));
        end
      end
      case (state_q)
        BkIdle: begin
          step_q <= StSq;
          if (q_valid_i) state_q <= BkBusy;
        end
        BkBusy: begin
          if (step_q == StOut) begin
            if (out_load) begin
              out_q.motion_north   <= dead_band(earth[0], cfg_i.deadband_xy);
              out_q.motion_east    <= dead_band(earth[1], cfg_i.deadband_xy);
              out_q.motion_up      <= dead_band(earth[2], cfg_i.deadband_z);
              out_q.yaw_total      <= job_q.yaw_total;
              out_q.attitude_ready <= job_q.ready;
              out_valid_q          <= 1'b1;
              state_q              <= BkIdle;
              step_q               <= StSq;
            end
          end else begin
            step_q <= step_q + 4'd1;
          end
        end
        default: state_q <= BkIdle;
      endcase
    end
  end

endmodule

@@ bench/tb_motion_accel_and_yaw_unwrap.sv @@
`timescale 1ns / 1ps
module tb_motion_accel_and_yaw_unwrap;
  import mau_pkg::*;

  localparam longint QHalf = 64'sd1 << 27;
  localparam int CycleLimit = 600000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we = 1'b0;
  logic [CfgIdxW-1:0] cfg_idx = '0;
  logic [CfgDataW-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  mau_in_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  mau_out_t out_data;

  motion_accel_and_yaw_unwrap DUT (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .cfg_we_i(cfg_we), .cfg_idx_i(cfg_idx), .cfg_data_i(cfg_data),
    .in_valid_i(in_valid), .in_stall_o(in_stall), .in_data_i(in_data),
    .out_valid_o(out_valid), .out_stall_i(out_stall), .out_data_o(out_data)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // shadow of the register file
  logic [15:0] alpha_r = 16'd3486;
  logic [14:0] gravity_r = 15'd10045;
  logic [11:0] band_xy_r = 12'd20;
  logic [11:0] band_z_r = 12'd41;
  logic [15:0] warmup_r = 16'd101;

  // filter and yaw state
  longint filt [3] = '{0, 0, 0};
  longint prev_yaw = 0;
  longint turns = 0;
  logic [15:0] warm_cnt = '0;
  logic ready = 1'b0;
  longint yaw_hold = 0;

  mau_in_t pending_q [$];
  mau_out_t motion_q [$];
  int snd_idle = 29, rcv_idle = 64;
  int errors = 0, n_requests = 0, n_results = 0, cycles = 0;

  function automatic longint rnd_shift(longint v, int s);
    longint half;
    half = 64'sd1 <<< (s - 1);
    if (v >= 0) return (v + half) >>> s;
    return -(((-v) + half) >>> s);
  endfunction

  function automatic longint clip20(longint v);
    if (v > 524287) return 524287;
    if (v < -524288) return -524288;
    return v;
  endfunction

  function automatic longint band_zero(longint v, logic [11:0] band);
    longint mag;
    mag = v < 0 ? -v : v;
    return mag < longint'(band) ? 0 : v;
  endfunction

  function automatic mau_out_t motion_step(mau_in_t it);
    longint w, x, y, z, yaw, grav, diff, st, sum, d, tot;
    longint r [3][3];
    longint acc [3];
    longint earth [3];
    mau_out_t o;
    w = it.quat_w; x = it.quat_x; y = it.quat_y; z = it.quat_z;
    yaw = it.yaw_angle;
    acc[0] = it.accel_x; acc[1] = it.accel_y; acc[2] = it.accel_z;
    r[0][0] = 2 * (QHalf - y * y - z * z);
    r[0][1] = 2 * (x * y - w * z);
    r[0][2] = 2 * (x * z + w * y);
    r[1][0] = 2 * (x * y + w * z);
    r[1][1] = 2 * (QHalf - x * x - z * z);
    r[1][2] = 2 * (y * z - w * x);
    r[2][0] = 2 * (x * z - w * y);
    r[2][1] = 2 * (y * z + w * x);
    r[2][2] = 2 * (QHalf - x * x - y * y);
    for (int i = 0; i < 3; i++) begin
      grav = rnd_shift(r[2][i] * longint'(gravity_r), 28);
      diff = acc[i] - grav;
      st = filt[i];
      st += rnd_shift(longint'(alpha_r) * (diff - st), 16);
      filt[i] = clip20(st);
    end
    for (int i = 0; i < 3; i++) begin
      sum = 0;
      for (int j = 0; j < 3; j++) sum += r[i][j] * filt[j];
      earth[i] = clip20(rnd_shift(sum, 28));
    end
    earth[0] = band_zero(earth[0], band_xy_r);
    earth[1] = band_zero(earth[1], band_xy_r);
    earth[2] = band_zero(earth[2], band_z_r);
    if (warm_cnt >= warmup_r) begin
      ready = 1'b1;
      d = yaw - prev_yaw;
      if (d >= 25736) begin
        if (turns > -32768) turns--;
      end else if (d <= -25736) begin
        if (turns < 32767) turns++;
      end
      tot = 51470 * turns + yaw;
      if (tot > 64'sd2147483647) tot = 64'sd2147483647;
      if (tot < -64'sd2147483648) tot = -64'sd2147483648;
      yaw_hold = tot;
      prev_yaw = yaw;
    end else begin
      warm_cnt = warm_cnt + 16'd1;
    end
    o.motion_north = 20'(earth[0]);
    o.motion_east = 20'(earth[1]);
    o.motion_up = 20'(earth[2]);
    o.yaw_total = 32'(yaw_hold);
    o.attitude_ready = ready;
    return o;
  endfunction

  // driver: predicts on acceptance, then offers the next request or idles
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid && !in_stall) begin
        motion_q.push_back(motion_step(in_data));
        n_requests++;
      end
      if (!in_valid || !in_stall) begin
        if (pending_q.size() > 0 && $urandom_range(0, 99) >= snd_idle) begin
          in_valid <= 1'b1;
          in_data <= pending_q.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("timeout after %0d cycles", cycles);
      $display("[FAIL] regression broken");
      $finish;
    end
    if (rst_ni) begin
      if (out_valid && !out_stall) begin
        n_results++;
        if (motion_q.size() == 0) begin
          errors++;
          if (errors <= 10) $display("result with no request outstanding");
        end else begin
          mau_out_t e;
          e = motion_q.pop_front();
          if (e != out_data) begin
            errors++;
            if (errors <= 10)
              $display({"mismatch #%0d exp n=%0d e=%0d u=%0d yaw=%0d rdy=%0d",
                        " | got n=%0d e=%0d u=%0d yaw=%0d rdy=%0d"},
                       n_results, e.motion_north, e.motion_east, e.motion_up, e.yaw_total,
                       e.attitude_ready, out_data.motion_north, out_data.motion_east,
                       out_data.motion_up, out_data.yaw_total, out_data.attitude_ready);
          end
        end
      end
      out_stall <= ($urandom_range(0, 99) < rcv_idle);
    end
  end

  task automatic write_regs(logic [15:0] a, logic [14:0] g, logic [11:0] bxy,
                            logic [11:0] bz, logic [15:0] wu);
    logic [15:0] vals [5];
    vals = '{a, 16'(g), 16'(bxy), 16'(bz), wu};
    for (int i = 0; i < 5; i++) begin
      @(posedge clk_i);
      cfg_we <= 1'b1;
      cfg_idx <= CfgIdxW'(i);
      cfg_data <= vals[i];
    end
    @(posedge clk_i);
    cfg_we <= 1'b0;
    alpha_r = a; gravity_r = g; band_xy_r = bxy; band_z_r = bz; warmup_r = wu;
  endtask

  // checked mid-cycle so the driver and monitor updates of the edge have settled
  task automatic drain();
    while (pending_q.size() > 0 || in_valid || motion_q.size() > 0) @(negedge clk_i);
    repeat (40) @(posedge clk_i);
  endtask

  function automatic mau_in_t mk(int qw, int qx, int qy, int qz, int ax, int ay, int az,
                                 int yw);
    mau_in_t it;
    it.quat_w = 16'(qw); it.quat_x = 16'(qx); it.quat_y = 16'(qy); it.quat_z = 16'(qz);
    it.accel_x = 20'(ax); it.accel_y = 20'(ay); it.accel_z = 20'(az);
    it.yaw_angle = 16'(yw);
    return it;
  endfunction

  int yaw_walk = 0;

  function automatic mau_in_t rand_request();
    mau_in_t it;
    real a, b, c, d, n;
    int sel;
    sel = $urandom_range(0, 99);
    if (sel < 8) begin
      // raw bits, unnormalised and out of range quaternions included
      it = mau_in_t'(140'({$urandom, $urandom, $urandom, $urandom, $urandom}));
      return it;
    end
    a = $itor($urandom_range(0, 2000)) - 1000.0;
    b = $itor($urandom_range(0, 2000)) - 1000.0;
    c = $itor($urandom_range(0, 2000)) - 1000.0;
    d = $itor($urandom_range(0, 2000)) - 1000.0;
    n = $sqrt(a * a + b * b + c * c + d * d);
    if (n < 1.0) begin
      a = 1.0; n = 1.0;
    end
    it.quat_w = 16'($rtoi(a / n * 16384.0));
    it.quat_x = 16'($rtoi(b / n * 16384.0));
    it.quat_y = 16'($rtoi(c / n * 16384.0));
    it.quat_z = 16'($rtoi(d / n * 16384.0));
    if (sel < 20) begin
      it.accel_x = 20'($urandom); it.accel_y = 20'($urandom); it.accel_z = 20'($urandom);
    end else begin
      it.accel_x = 20'(int'($urandom_range(0, 8000)) - 4000);
      it.accel_y = 20'(int'($urandom_range(0, 8000)) - 4000);
      it.accel_z = 20'(int'($urandom_range(0, 8000)) - 4000 + int'(gravity_r));
    end
    // yaw mostly drifts and wraps at half a turn, sometimes jumps anywhere
    if (sel < 90) begin
      yaw_walk += int'($urandom_range(0, 12000)) - 6000;
      if (yaw_walk > 25736) yaw_walk -= 51470;
      if (yaw_walk < -25736) yaw_walk += 51470;
    end else begin
      yaw_walk = int'($signed(16'($urandom)));
    end
    it.yaw_angle = 16'(yaw_walk);
    return it;
  endfunction

  initial begin
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: identity and flipped attitudes, field extremes, yaw wrap both ways
    pending_q.push_back(mk(16384, 0, 0, 0, 0, 0, 10045, 0));
    pending_q.push_back(mk(-16384, 0, 0, 0, 0, 0, 10045, 25736));
    pending_q.push_back(mk(0, 16384, 0, 0, 0, 0, -10045, -25736));
    pending_q.push_back(mk(0, 0, 16384, 0, 524287, 524287, 524287, 25736));
    pending_q.push_back(mk(0, 0, 0, 16384, -524288, -524288, -524288, -25736));
    pending_q.push_back(mk(0, 0, 0, -16384, 524287, -524288, 0, 0));
    pending_q.push_back(mk(16384, 16384, 16384, 16384, 524287, 524287, 524287, 32767));
    pending_q.push_back(mk(-32768, -32768, -32768, -32768, -524288, 0, 524287, -32768));
    pending_q.push_back(mk(32767, -32768, 32767, -32768, 0, 0, 0, 32767));
    pending_q.push_back(mk(11585, 11585, 0, 0, 19, -20, 40, 12000));
    pending_q.push_back(mk(11585, 0, 0, 11585, -19, 20, -41, -12000));
    pending_q.push_back(mk(16384, 0, 0, 0, 20, -19, 41, 0));
    for (int i = 0; i < 320; i++) pending_q.push_back(rand_request());
    drain();

    // extremes: full alpha, max gravity, no xy band, widest z band, no warm-up
    snd_idle = 64; rcv_idle = 29;
    write_regs(16'hffff, 15'h7fff, 12'd0, 12'hfff, 16'd0);
    pending_q.push_back(mk(16384, 0, 0, 0, 0, 0, 0, 25000));
    pending_q.push_back(mk(16384, 0, 0, 0, 0, 0, 0, -25000));
    pending_q.push_back(mk(16384, 0, 0, 0, 0, 0, 0, 25000));
    for (int i = 0; i < 340; i++) pending_q.push_back(rand_request());
    drain();

    // frozen filter, no gravity, warm-up raised after ready
    snd_idle = 0; rcv_idle = 0;
    write_regs(16'd0, 15'd0, 12'hfff, 12'd0, 16'hffff);
    for (int i = 0; i < 330; i++) pending_q.push_back(rand_request());
    drain();

    // back to everyday values with unwrapping on again
    write_regs(16'($urandom_range(1, 65534)), 15'd10045, 12'd20, 12'd41, 16'd5);
    for (int i = 0; i < 340; i++) pending_q.push_back(rand_request());
    drain();

    $display("%0d requests sent, %0d results checked over four register settings",
             n_requests, n_results);
    $display("sender and receiver idling swapped, then back-to-back; %0d errors", errors);
    if (errors == 0 && motion_q.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
